/* hdl/assert_macros.svh */
// Assertion macros shared by the colormap RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check, always on (including reset).
`define ASSERT_ANY(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/ejc_pkg.sv */
// Types and constants for the extended jet colormap.
package ejc_pkg;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      REG_RANGE_LOW   = 2'd0,
      REG_RANGE_SCALE = 2'd1,
      REG_GO_PAST_MAX = 2'd2
   } csr_reg_type;

   localparam logic [31:0] RANGE_LOW_RESET   = 32'd0;
   localparam logic [31:0] RANGE_SCALE_RESET = 32'd4096;
   localparam logic        GO_PAST_MAX_RESET = 1'b1;

   typedef struct packed {
      logic signed [31:0] range_low;
      logic [31:0]        range_scale;
      logic               go_past_max;
   } cfg_type;

   localparam int COLOUR_BITS = 13;
   typedef logic [COLOUR_BITS-1:0] colour_type;

   localparam colour_type C_ONE_EIGHTH   = 13'd512;
   localparam colour_type C_THREE_EIGHTH = 13'd1536;
   localparam colour_type C_FIVE_EIGHTH  = 13'd2560;
   localparam colour_type C_SEVEN_EIGHTH = 13'd3584;
   localparam colour_type C_ONE          = 13'd4096;
   localparam colour_type C_NINE_EIGHTH  = 13'd4608;
   localparam colour_type C_FIVE_FOURTH  = 13'd5120;
   localparam colour_type C_THREE_HALF   = 13'd6144;

   localparam int OPERAND_BITS = 11;
   typedef logic [OPERAND_BITS-1:0] operand_type;
   localparam operand_type RAMP_MAX = 11'd1024;

   localparam int SLOPE_BITS = 10;
   localparam logic [SLOPE_BITS-1:0] C_SLOPE = 10'd1020;
   localparam int RAMP_SHIFT = 12;
   localparam int RAMP_PROD_BITS = OPERAND_BITS + SLOPE_BITS;

   localparam logic [7:0] LEVEL_ZERO     = 8'd0;
   localparam logic [7:0] LEVEL_FULL     = 8'd255;
   localparam logic [7:0] LEVEL_DARK_RED = 8'd128;

   typedef struct packed {
      logic        use_ramp;
      operand_type operand;
      logic [7:0]  level;
   } plan_type;

endpackage

/* hdl/ejc_req_if.sv */
// Request channel: one signed sample per transfer.
interface ejc_req_if #(
   parameter int SAMPLE_BITS = 32
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

/* hdl/ejc_rsp_if.sv */
// Response channel: one RGB pixel per transfer.
interface ejc_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

/* hdl/ejc_csr.sv */
// APB-style configuration registers of the colormap.
module ejc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ejc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [ejc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [ejc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready,
   output ejc_pkg::cfg_type                  cfg
);

   logic [31:0]          range_low_ff;
   logic [31:0]          range_scale_ff;
   logic                 go_past_max_ff;
   logic                 write_en;
   ejc_pkg::csr_reg_type reg_sel;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = ejc_pkg::csr_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff   <= ejc_pkg::RANGE_LOW_RESET;
         range_scale_ff <= ejc_pkg::RANGE_SCALE_RESET;
         go_past_max_ff <= ejc_pkg::GO_PAST_MAX_RESET;
      end else if (write_en) begin
         unique case (reg_sel)
            ejc_pkg::REG_RANGE_LOW:   range_low_ff   <= csr_pwdata;
            ejc_pkg::REG_RANGE_SCALE: range_scale_ff <= csr_pwdata;
            ejc_pkg::REG_GO_PAST_MAX: go_past_max_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         ejc_pkg::REG_RANGE_LOW:   csr_prdata = range_low_ff;
         ejc_pkg::REG_RANGE_SCALE: csr_prdata = range_scale_ff;
         ejc_pkg::REG_GO_PAST_MAX: csr_prdata = {31'd0, go_past_max_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   assign cfg.range_low   = range_low_ff;
   assign cfg.range_scale = range_scale_ff;
   assign cfg.go_past_max = go_past_max_ff;

endmodule

/* hdl/ejc_norm.sv */
// Normalization pipeline: offset, scale multiply, clamp to colour units.
`include "assert_macros.svh"

module ejc_norm #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ejc_pkg::cfg_type       cfg,
   ejc_req_if.sink                req_chan,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ejc_pkg::colour_type    out_colour
);

   localparam int DIFF_BITS = (SAMPLE_BITS > 32 ? SAMPLE_BITS : 32) + 2;

   logic                 en1, en2, en3;
   logic                 v1_ff, v2_ff, v3_ff;
   logic [DIFF_BITS-1:0] sample_ext, low_ext, diff;
   logic                 pos1_in, big1_in;
   logic                 pos1_ff, big1_ff;
   logic [31:0]          mag1_ff;
   logic [63:0]          prod2_ff;
   logic                 zero2_ff, sat2_ff;
   ejc_pkg::colour_type  colour3_in, colour3_ff;

   assign en3 = !v3_ff || out_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;

   // stage 1: signed offset
   assign sample_ext = {{(DIFF_BITS-SAMPLE_BITS){req_chan.sample[SAMPLE_BITS-1]}},
                        req_chan.sample};
   assign low_ext    = {{(DIFF_BITS-32){cfg.range_low[31]}}, cfg.range_low};
   assign diff       = sample_ext - low_ext;
   assign pos1_in    = !diff[DIFF_BITS-1] && (|diff);
   assign big1_in    = |diff[DIFF_BITS-2:32];

   // stage 3: clamp to 0..1.5
   always_comb begin
      if (zero2_ff) begin
         colour3_in = '0;
      end else if (sat2_ff || (|prod2_ff[63:29]) ||
                   (prod2_ff[28:16] > ejc_pkg::C_THREE_HALF)) begin
         colour3_in = ejc_pkg::C_THREE_HALF;
      end else begin
         colour3_in = prod2_ff[28:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         pos1_ff <= pos1_in;
         big1_ff <= big1_in;
         mag1_ff <= diff[31:0];
      end
      if (en2) begin
         prod2_ff <= mag1_ff * cfg.range_scale;
         zero2_ff <= !pos1_ff || (cfg.range_scale == 32'd0);
         sat2_ff  <= big1_ff;
      end
      if (en3) begin
         colour3_ff <= colour3_in;
      end
   end

   assign out_valid  = v3_ff;
   assign out_colour = colour3_ff;

   `ASSERT_CLK(a_colour_range, clock, reset, v3_ff |-> (colour3_ff <= ejc_pkg::C_THREE_HALF), "colour above 1.5")
   `ASSERT_ANY(a_reset_flush, clock, $past(reset) |-> !(v1_ff || v2_ff || v3_ff), "valid survived reset")

endmodule

/* hdl/ejc_shade.sv */
// Jet ramp pipeline: segment select, slope multiply, pixel output register.
`include "assert_macros.svh"

module ejc_shade (
   input  logic                clock,
   input  logic                reset,
   input  logic                go_past_max,
   input  logic                in_valid,
   output logic                in_ready,
   input  ejc_pkg::colour_type in_colour,
   ejc_rsp_if.source           rsp_chan
);

   logic                en4, en5;
   logic                v4_ff, v5_ff;
   ejc_pkg::plan_type   red_in, green_in, blue_in;
   ejc_pkg::plan_type   red4_ff, green4_ff, blue4_ff;
   logic [7:0]          red5_ff, green5_ff, blue5_ff;
   ejc_pkg::colour_type c;
   logic                operands_ok;

   function automatic ejc_pkg::plan_type flat(input logic [7:0] level);
      ejc_pkg::plan_type p;
      p.use_ramp = 1'b0;
      p.operand  = '0;
      p.level    = level;
      return p;
   endfunction

   function automatic ejc_pkg::plan_type slope(input ejc_pkg::colour_type op);
      ejc_pkg::plan_type p;
      p.use_ramp = 1'b1;
      p.operand  = op[ejc_pkg::OPERAND_BITS-1:0];
      p.level    = ejc_pkg::LEVEL_ZERO;
      return p;
   endfunction

   function automatic logic [7:0] shade(input ejc_pkg::plan_type p);
      logic [ejc_pkg::RAMP_PROD_BITS-1:0] prod;
      prod = ejc_pkg::RAMP_PROD_BITS'(p.operand) * ejc_pkg::RAMP_PROD_BITS'(ejc_pkg::C_SLOPE);
      return p.use_ramp ? prod[ejc_pkg::RAMP_SHIFT+7:ejc_pkg::RAMP_SHIFT] : p.level;
   endfunction

   assign en5      = !v5_ff || rsp_chan.ready;
   assign en4      = !v4_ff || en5;
   assign in_ready = en4;
   assign c        = in_colour;

   // stage 4: pick segment
   always_comb begin
      red_in   = flat(ejc_pkg::LEVEL_ZERO);
      green_in = flat(ejc_pkg::LEVEL_ZERO);
      blue_in  = flat(ejc_pkg::LEVEL_ZERO);
      if (c < ejc_pkg::C_ONE_EIGHTH) begin
         blue_in  = slope(c + ejc_pkg::C_ONE_EIGHTH);
      end else if (c < ejc_pkg::C_THREE_EIGHTH) begin
         green_in = slope(c - ejc_pkg::C_ONE_EIGHTH);
         blue_in  = flat(ejc_pkg::LEVEL_FULL);
      end else if (c < ejc_pkg::C_FIVE_EIGHTH) begin
         red_in   = slope(c - ejc_pkg::C_THREE_EIGHTH);
         green_in = flat(ejc_pkg::LEVEL_FULL);
         blue_in  = slope(ejc_pkg::C_FIVE_EIGHTH - c);
      end else if (c < ejc_pkg::C_SEVEN_EIGHTH) begin
         red_in   = flat(ejc_pkg::LEVEL_FULL);
         green_in = slope(ejc_pkg::C_SEVEN_EIGHTH - c);
      end else if (c < ejc_pkg::C_ONE) begin
         red_in   = slope(ejc_pkg::C_NINE_EIGHTH - c);
      end else if (!go_past_max) begin
         red_in   = flat(ejc_pkg::LEVEL_DARK_RED);
      end else if (c < ejc_pkg::C_NINE_EIGHTH) begin
         red_in   = slope(c - ejc_pkg::C_SEVEN_EIGHTH);
         blue_in  = slope(c - ejc_pkg::C_ONE);
      end else if (c < ejc_pkg::C_FIVE_FOURTH) begin
         red_in   = flat(ejc_pkg::LEVEL_FULL);
         blue_in  = slope(c - ejc_pkg::C_ONE);
      end else if (c < ejc_pkg::C_THREE_HALF) begin
         red_in   = flat(ejc_pkg::LEVEL_FULL);
         green_in = slope(c - ejc_pkg::C_FIVE_FOURTH);
         blue_in  = flat(ejc_pkg::LEVEL_FULL);
      end else begin
         red_in   = flat(ejc_pkg::LEVEL_FULL);
         green_in = flat(ejc_pkg::LEVEL_FULL);
         blue_in  = flat(ejc_pkg::LEVEL_FULL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en4) v4_ff <= in_valid;
         if (en5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         red4_ff   <= red_in;
         green4_ff <= green_in;
         blue4_ff  <= blue_in;
      end
      if (en5) begin
         red5_ff   <= shade(red4_ff);
         green5_ff <= shade(green4_ff);
         blue5_ff  <= shade(blue4_ff);
      end
   end

   assign rsp_chan.valid = v5_ff;
   assign rsp_chan.red   = red5_ff;
   assign rsp_chan.green = green5_ff;
   assign rsp_chan.blue  = blue5_ff;

   assign operands_ok = (!red4_ff.use_ramp   || red4_ff.operand   <= ejc_pkg::RAMP_MAX) &&
                        (!green4_ff.use_ramp || green4_ff.operand <= ejc_pkg::RAMP_MAX) &&
                        (!blue4_ff.use_ramp  || blue4_ff.operand  <= ejc_pkg::RAMP_MAX);

   `ASSERT_CLK(a_operand_range, clock, reset, v4_ff |-> operands_ok, "ramp operand above 1024")

endmodule

/* hdl/extended_jet_colormap_unit.sv */
// Top level of the extended jet colormap: sample in, RGB pixel out.
//
//   port       dir   protocol        content
//   req_chan   in    valid/ready     sample, signed Q16.16
//   rsp_chan   out   valid/ready     red, green, blue bytes
//   csr_*      in    APB-style       range_low @0x0, range_scale @0x4, go_past_max @0x8
//
// One request per clock unless rsp_chan back-pressure stalls the pipeline; five register stages.
// Stages: offset, 32x32 scale multiply, clamp, segment select, slope multiply.
// Synchronous active-high reset empties the pipeline and loads register defaults.
// Each stage holds while its successor is full and stalled; bubbles collapse, nothing drops.
module extended_jet_colormap_unit #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   ejc_req_if.sink                           req_chan,
   ejc_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ejc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [ejc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [ejc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   ejc_pkg::cfg_type    cfg;
   logic                norm_valid;
   logic                norm_ready;
   ejc_pkg::colour_type norm_colour;

   ejc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ejc_norm #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_norm (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_chan   (req_chan),
      .out_valid  (norm_valid),
      .out_ready  (norm_ready),
      .out_colour (norm_colour)
   );

   ejc_shade u_shade (
      .clock       (clock),
      .reset       (reset),
      .go_past_max (cfg.go_past_max),
      .in_valid    (norm_valid),
      .in_ready    (norm_ready),
      .in_colour   (norm_colour),
      .rsp_chan    (rsp_chan)
   );

endmodule
